/* rtl/core/perm_pkg.sv */
package perm_pkg;

  // Number of entries in the stored permutation.
  localparam int PermSize = 48;

  // Field widths fixed by the item format.
  localparam int ElemW = 6;
  localparam int CntW = 7;

  // Entry index and memory address (two banks of PermSize entries).
  localparam int IdxW = $clog2(PermSize);
  localparam int Depth = 2 * PermSize;
  localparam int AddrW = $clog2(Depth);
  localparam int CntMax = (1 << CntW) - 1;

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [AddrW-1:0] addr_t;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_COMPOSE  = 3'd1,
    OP_INVERT   = 3'd2,
    OP_IDENTITY = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INV
  } state_t;

  // Address of entry idx in the given bank.
  function automatic addr_t mem_addr(logic bank, idx_t idx);
    addr_t base;
    base = bank ? addr_t'(PermSize) : addr_t'(0);
    return base + addr_t'(idx);
  endfunction

endpackage

/* rtl/core/permutation_engine_core.sv */
// Permutation engine: holds one permutation of 48 one-based entries in two
// memory banks (entry map and its inverse), one bank pair current and the
// other collecting an incoming load or compose stream; a correct stream end
// swaps the banks, so no copy is needed. Each load, compose, read or identity
// item has an accept cycle, which reads the memories for compose and read, and
// in the cycle after it an execute cycle that checks the element, writes back
// and loads the result register; that execute cycle repeats while an earlier
// result still waits at a stalled output. Invert yields 48 results, one result
// per cycle while the output is not stalled, read from the stored inverse map.
// Reset and identity act at once through per-entry valid flags, so there is
// no clearing pass. A new item is accepted while an earlier result still
// waits to be taken at the output.
module permutation_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [5:0] in_element,
  input  logic [5:0] in_position,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_value,
  output logic [1:0] out_status,
  output logic       out_last_out
);

  // Sequencer and stream state.
  perm_pkg::state_t  state_r, state_nxt;
  logic              bank_r, bank_nxt;
  logic [perm_pkg::Depth-1:0]    p_vld_r, p_vld_nxt;
  logic [perm_pkg::Depth-1:0]    q_vld_r, q_vld_nxt;
  logic [perm_pkg::PermSize-1:0] seen_r, seen_nxt;
  perm_pkg::cnt_t    cnt_r, cnt_nxt;
  perm_pkg::status_t ferr_r, ferr_nxt;
  logic              kind_r, kind_nxt;
  perm_pkg::idx_t    inv_idx_r, inv_idx_nxt;

  // Item held for the execute cycle.
  logic [2:0]        op_r;
  perm_pkg::elem_t   elem_r;
  perm_pkg::elem_t   pos_r;
  logic              last_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  perm_pkg::elem_t   out_value_r, out_value_nxt;
  perm_pkg::status_t out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ld;

  // Entry map memory and inverse map memory.
  perm_pkg::elem_t   p_mem [perm_pkg::Depth];
  perm_pkg::elem_t   q_mem [perm_pkg::Depth];
  logic              p_re, p_we, q_re, q_we;
  perm_pkg::addr_t   p_raddr, p_waddr, q_raddr, q_waddr;
  perm_pkg::elem_t   p_wdata, q_wdata;
  perm_pkg::idx_t    p_ridx, q_ridx;
  perm_pkg::elem_t   p_rd_r, q_rd_r, p_dflt_r, q_dflt_r;
  logic              p_rvld_r, q_rvld_r;
  perm_pkg::elem_t   p_val, q_val;

  // Element check signals.
  logic              in_fire, out_free, exec_fire, need_out;
  logic              is_compose, start;
  perm_pkg::cnt_t    cnt_eff, cnt_inc;
  perm_pkg::status_t ferr_eff, ferr_upd, el_st, fin_st;
  logic [perm_pkg::PermSize-1:0] seen_eff;
  perm_pkg::idx_t    e_idx;
  logic              e_in_rng;
  perm_pkg::elem_t   entry;

  assign in_stall = (state_r != perm_pkg::S_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // An entry without its valid flag reads as the identity value.
  assign p_val = p_rvld_r ? p_rd_r : p_dflt_r;
  assign q_val = q_rvld_r ? q_rd_r : q_dflt_r;

  // Element checks for a load or compose element in the execute cycle.
  always_comb begin
    is_compose = (op_r == perm_pkg::OP_COMPOSE);
    start = (cnt_r == '0) || (kind_r != is_compose);
    cnt_eff = start ? '0 : cnt_r;
    ferr_eff = start ? perm_pkg::ST_OK : ferr_r;
    seen_eff = start ? '0 : seen_r;
    e_idx = perm_pkg::idx_t'(elem_r - 6'd1);
    e_in_rng = (elem_r != '0) && ({1'b0, elem_r} <= perm_pkg::cnt_t'(perm_pkg::PermSize));
    priority if (cnt_eff >= perm_pkg::cnt_t'(perm_pkg::PermSize)) begin
      el_st = perm_pkg::ST_LENGTH;
    end else if (!e_in_rng) begin
      el_st = perm_pkg::ST_RANGE;
    end else if (seen_eff[e_idx]) begin
      el_st = perm_pkg::ST_DUP;
    end else begin
      el_st = perm_pkg::ST_OK;
    end
    entry = is_compose ? p_val : elem_r;
    cnt_inc = (cnt_eff == perm_pkg::cnt_t'(perm_pkg::CntMax)) ? cnt_eff : cnt_eff + 7'd1;
    ferr_upd = ferr_eff;
    if (ferr_eff == perm_pkg::ST_OK &&
        (el_st == perm_pkg::ST_RANGE || el_st == perm_pkg::ST_DUP)) begin
      ferr_upd = el_st;
    end
    fin_st = (cnt_inc != perm_pkg::cnt_t'(perm_pkg::PermSize)) ? perm_pkg::ST_LENGTH
                                                               : ferr_upd;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_nxt = state_r;
    bank_nxt = bank_r;
    p_vld_nxt = p_vld_r;
    q_vld_nxt = q_vld_r;
    seen_nxt = seen_r;
    cnt_nxt = cnt_r;
    ferr_nxt = ferr_r;
    kind_nxt = kind_r;
    inv_idx_nxt = inv_idx_r;
    p_re = 1'b0;
    p_ridx = '0;
    q_re = 1'b0;
    q_ridx = '0;
    p_we = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    q_we = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    out_ld = 1'b0;
    out_value_nxt = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt = out_last_r;
    need_out = 1'b0;
    exec_fire = 1'b0;

    unique case (state_r)
      perm_pkg::S_IDLE: begin
        // Accept cycle: read the current bank for compose and read items.
        if (in_fire) begin
          state_nxt = perm_pkg::S_EXEC;
          if (in_op == perm_pkg::OP_COMPOSE) begin
            p_re = (in_element != '0) &&
                   ({1'b0, in_element} <= perm_pkg::cnt_t'(perm_pkg::PermSize));
            p_ridx = perm_pkg::idx_t'(in_element - 6'd1);
          end else if (in_op == perm_pkg::OP_READ) begin
            p_re = ({1'b0, in_position} < perm_pkg::cnt_t'(perm_pkg::PermSize));
            p_ridx = perm_pkg::idx_t'(in_position);
          end
        end
      end

      perm_pkg::S_EXEC: begin
        need_out = (op_r == perm_pkg::OP_COMPOSE) || (op_r == perm_pkg::OP_READ) ||
                   (op_r == perm_pkg::OP_LOAD && last_r);
        exec_fire = !need_out || out_free;
        if (exec_fire) begin
          state_nxt = perm_pkg::S_IDLE;
          unique case (op_r)
            perm_pkg::OP_LOAD, perm_pkg::OP_COMPOSE: begin
              // Check the element, write it to the work bank and close the stream.
              seen_nxt = seen_eff;
              kind_nxt = is_compose;
              if (el_st == perm_pkg::ST_OK) begin
                seen_nxt[e_idx] = 1'b1;
                p_we = 1'b1;
                p_waddr = perm_pkg::mem_addr(!bank_r, perm_pkg::idx_t'(cnt_eff));
                p_wdata = entry;
                p_vld_nxt[p_waddr] = 1'b1;
                q_we = 1'b1;
                q_waddr = perm_pkg::mem_addr(!bank_r, perm_pkg::idx_t'(entry - 6'd1));
                q_wdata = perm_pkg::elem_t'(cnt_eff + 7'd1);
                q_vld_nxt[q_waddr] = 1'b1;
              end
              if (last_r) begin
                cnt_nxt = '0;
                ferr_nxt = perm_pkg::ST_OK;
                if (fin_st == perm_pkg::ST_OK) begin
                  bank_nxt = !bank_r;
                end
              end else begin
                cnt_nxt = cnt_inc;
                ferr_nxt = ferr_upd;
              end
              if (need_out) begin
                out_ld = 1'b1;
                out_status_nxt = last_r ? fin_st : el_st;
                out_last_nxt = last_r;
                out_value_nxt = (is_compose && out_status_nxt == perm_pkg::ST_OK) ? entry
                                                                                  : '0;
              end
            end
            perm_pkg::OP_INVERT: begin
              // Start the inverse sweep with entry zero.
              state_nxt = perm_pkg::S_INV;
              inv_idx_nxt = '0;
              q_re = 1'b1;
              q_ridx = '0;
            end
            perm_pkg::OP_IDENTITY: begin
              for (int i = 0; i < perm_pkg::PermSize; i++) begin
                p_vld_nxt[perm_pkg::mem_addr(bank_r, perm_pkg::idx_t'(i))] = 1'b0;
                q_vld_nxt[perm_pkg::mem_addr(bank_r, perm_pkg::idx_t'(i))] = 1'b0;
              end
            end
            perm_pkg::OP_READ: begin
              out_ld = 1'b1;
              out_last_nxt = 1'b1;
              if ({1'b0, pos_r} < perm_pkg::cnt_t'(perm_pkg::PermSize)) begin
                out_value_nxt = p_val;
                out_status_nxt = perm_pkg::ST_OK;
              end else begin
                out_value_nxt = '0;
                out_status_nxt = perm_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      perm_pkg::S_INV: begin
        // One inverse entry per free output slot, next read issued alongside.
        if (out_free) begin
          out_ld = 1'b1;
          out_value_nxt = q_val;
          out_status_nxt = perm_pkg::ST_OK;
          out_last_nxt = (inv_idx_r == perm_pkg::idx_t'(perm_pkg::PermSize - 1));
          if (out_last_nxt) begin
            state_nxt = perm_pkg::S_IDLE;
          end else begin
            inv_idx_nxt = inv_idx_r + 1'b1;
            q_re = 1'b1;
            q_ridx = inv_idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = perm_pkg::S_IDLE;
      end
    endcase

    p_raddr = perm_pkg::mem_addr(bank_r, p_ridx);
    q_raddr = perm_pkg::mem_addr(bank_r, q_ridx);

    // The result register empties on a transfer and refills on a load.
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= perm_pkg::S_IDLE;
      bank_r <= 1'b0;
      p_vld_r <= '0;
      q_vld_r <= '0;
      seen_r <= '0;
      cnt_r <= '0;
      ferr_r <= perm_pkg::ST_OK;
      kind_r <= 1'b0;
      inv_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bank_r <= bank_nxt;
      p_vld_r <= p_vld_nxt;
      q_vld_r <= q_vld_nxt;
      seen_r <= seen_nxt;
      cnt_r <= cnt_nxt;
      ferr_r <= ferr_nxt;
      kind_r <= kind_nxt;
      inv_idx_r <= inv_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_op;
      elem_r <= in_element;
      pos_r <= in_position;
      last_r <= in_last;
    end
    out_value_r <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r <= out_last_nxt;
  end

  // Entry map memory with registered read.
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rd_r <= p_mem[p_raddr];
      p_rvld_r <= p_vld_r[p_raddr];
      p_dflt_r <= perm_pkg::elem_t'(p_ridx) + 6'd1;
    end
  end

  // Inverse map memory with registered read.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_r <= q_mem[q_raddr];
      q_rvld_r <= q_vld_r[q_raddr];
      q_dflt_r <= perm_pkg::elem_t'(q_ridx) + 6'd1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_status = out_status_r;
  assign out_last_out = out_last_r;

  // The banks swap only as the result of an executed stream element.
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_r != $past(bank_r)) |-> $past(state_r == perm_pkg::S_EXEC))
    else $error("bank swap outside the execute cycle");

  // Stream writes never touch the current bank.
  a_work_write: assert property (@(posedge clk) disable iff (!rst_n)
    (p_we || q_we) |->
      ((p_waddr >= perm_pkg::addr_t'(perm_pkg::PermSize)) != bank_r) &&
      ((q_waddr >= perm_pkg::addr_t'(perm_pkg::PermSize)) != bank_r))
    else $error("stream write into the current bank");

  // The inverse sweep stays within the permutation.
  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == perm_pkg::S_INV) |->
      (perm_pkg::cnt_t'(inv_idx_r) < perm_pkg::cnt_t'(perm_pkg::PermSize)))
    else $error("inverse index beyond the permutation");

endmodule
